[sv/ulp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Unsigned integer literal parser package
// Character codes and result status codes that the parser uses.
// ----------------------------------------------------------------------------
package ulp_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_NO_DIGIT = 2'd1;
	localparam status_t ST_OVERFLOW = 2'd2;

	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_X = 8'h78;
	localparam logic [7:0] CH_UPPER_X = 8'h58;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;

endpackage
`default_nettype wire

[sv/unsigned_integer_literal_parser.sv]
// An item accepted into the input register has its result, if any, registered
// from there into the result register. One item per cycle, but for the stall
// below; the only recurrence is the accumulator update (a shift-add with a compare).
// An item that ends the literal waits in the input register while the result
// register is still full. Reset (arst_n low, asynchronous) empties both
// registers, sets the parser to await a first digit and selects 64-bit width.
`default_nettype none
// ----------------------------------------------------------------------------
// Unsigned integer literal parser
// Parses a decimal or 0x hex literal one character per item, with an exact
// overflow check at 32-bit or 64-bit width.
// ----------------------------------------------------------------------------
module unsigned_integer_literal_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       char_code,
	input  wire logic             end_of_text,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [63:0]           value,
	output ulp_pkg::status_t      status,
	output logic                  was_hex,
	output logic [7:0]            stop_char,
	output logic                  stopped_by_end
);
	import ulp_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_ZEROS, PH_DEC, PH_HEX} phase_t;

	logic        wm_q;
	phase_t      phase_q, phase_d;
	logic [63:0] acc_q, acc_d;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;

	logic        out_valid_q;
	logic [63:0] value_q;
	status_t     status_q;
	logic        was_hex_q;
	logic [7:0]  stop_char_q;
	logic        stopped_by_end_q;

	logic        emit, adv, out_free;
	logic [63:0] res_value;
	status_t     res_status;
	logic        res_hex;
	logic [7:0]  res_stop;

	logic        common, cm_hex;
	logic [63:0] cm_acc;
	logic        is_dec, is_hex_letter, digit_ok, ovf;
	logic [3:0]  dig;
	logic [67:0] acc_ext, prod, sum;
	logic [63:0] mx;

	assign is_dec        = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign is_hex_letter = ((char_s1 >= CH_LOWER_A) && (char_s1 <= CH_LOWER_F)) ||
	                       ((char_s1 >= CH_UPPER_A) && (char_s1 <= CH_UPPER_F));
	assign digit_ok      = is_dec || (cm_hex && is_hex_letter);
	// Letters a-f and A-F carry 1..6 in their low nibble.
	assign dig           = is_dec ? char_s1[3:0] : 4'(char_s1[3:0] + 4'd9);

	assign mx      = wm_q ? {64{1'b1}} : {32'b0, {32{1'b1}}};
	assign acc_ext = {4'b0, cm_acc};
	assign prod    = cm_hex ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1));
	assign sum     = prod + {64'b0, dig};
	// The exact sum is compared with the width limit, which matches the
	// divide-and-compare check for every accumulator value.
	assign ovf     = (|sum[67:64]) || (!wm_q && (|sum[63:32]));

	always_comb begin
		emit       = 1'b0;
		res_value  = '0;
		res_status = ST_OK;
		res_hex    = 1'b0;
		res_stop   = eot_s1 ? 8'd0 : char_s1;
		phase_d    = phase_q;
		acc_d      = acc_q;
		common     = 1'b0;
		cm_hex     = (phase_q == PH_HEX);
		cm_acc     = acc_q;
		case (phase_q)
			PH_IDLE: begin
				if (eot_s1 || !is_dec) begin
					emit       = 1'b1;
					res_status = ST_NO_DIGIT;
				end else if (char_s1 == CH_ZERO) begin
					phase_d = PH_ZEROS;
					acc_d   = '0;
				end else begin
					phase_d = PH_DEC;
					acc_d   = {60'b0, char_s1[3:0]};
				end
			end
			PH_ZEROS: begin
				if (eot_s1) begin
					emit = 1'b1;
				end else if (char_s1 == CH_ZERO) begin
					phase_d = PH_ZEROS;
				end else if (char_s1 == CH_LOWER_X || char_s1 == CH_UPPER_X) begin
					phase_d = PH_HEX;
					acc_d   = '0;
				end else begin
					// Any other character is handled by the decimal rules with a zero accumulator.
					common  = 1'b1;
					cm_hex  = 1'b0;
					cm_acc  = '0;
					phase_d = PH_DEC;
				end
			end
			default: begin
				common = 1'b1;
			end
		endcase
		if (common) begin
			res_hex = cm_hex;
			if (eot_s1 || !digit_ok) begin
				emit      = 1'b1;
				res_value = cm_acc & mx;
			end else if (ovf) begin
				emit       = 1'b1;
				res_status = ST_OVERFLOW;
			end else begin
				acc_d = sum[63:0];
			end
		end
		if (emit) begin
			phase_d = PH_IDLE;
			acc_d   = '0;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q        <= 1'b1;
			phase_q     <= PH_IDLE;
			acc_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wm_q <= cfg_wdata;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
			end
			if (adv && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_code;
			eot_s1  <= end_of_text;
		end
		if (adv && emit) begin
			value_q          <= res_value;
			status_q         <= res_status;
			was_hex_q        <= res_hex;
			stop_char_q      <= res_stop;
			stopped_by_end_q <= eot_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign status         = status_q;
	assign was_hex        = was_hex_q;
	assign stop_char      = stop_char_q;
	assign stopped_by_end = stopped_by_end_q;

	// A failed parse never reports a value.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_OK) |-> (value_q == 64'd0))
		else $error("error result carries a nonzero value");

	// A literal that ended at end of text has no stop character.
	a_end_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stopped_by_end_q |-> (stop_char_q == 8'd0))
		else $error("end of text result with a stop character");

	// A missing first digit is never reported as hex.
	a_nodig_dec: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == ST_NO_DIGIT) |-> !was_hex_q)
		else $error("start error flagged as hex");

	// Every result returns the parser to the start of a literal.
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |=> (phase_q == PH_IDLE) && (acc_q == 64'd0))
		else $error("parser did not return to idle after a result");

	// A stalled item stays in the input register untouched.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(char_s1) && $stable(eot_s1))
		else $error("stalled item lost or changed");

endmodule
`default_nettype wire

[tb/literal_parse_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Literal parse checker
// Watches the character and result channels of the literal parser. It keeps
// its own copy of the parse state and the width setting, works out the
// result that each accepted item causes, and compares every accepted result
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module literal_parse_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [7:0]       char_code,
	input  logic             end_of_text,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [63:0]      value,
	input  ulp_pkg::status_t status,
	input  logic             was_hex,
	input  logic [7:0]       stop_char,
	input  logic             stopped_by_end,
	output int               mismatches,
	output int               pending_results
);
	import ulp_pkg::*;

	typedef enum logic [1:0] {LIT_IDLE, LIT_ZEROS, LIT_DEC, LIT_HEX} lit_phase_t;

	typedef struct packed {
		logic [63:0] value;
		status_t     status;
		logic        was_hex;
		logic [7:0]  stop_char;
		logic        stopped_by_end;
	} literal_result_t;

	literal_result_t expected_literals[$];
	lit_phase_t      lit_phase;
	logic [63:0]     acc;
	logic            wide_mode;

	initial mismatches = 0;
	initial pending_results = 0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic int digit_value(input logic [7:0] c, input bit hex);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (hex && c >= CH_LOWER_A && c <= CH_LOWER_F)
			return int'(c - CH_LOWER_A) + 10;
		if (hex && c >= CH_UPPER_A && c <= CH_UPPER_F)
			return int'(c - CH_UPPER_A) + 10;
		return -1;
	endfunction

	task automatic close_literal(input logic [63:0] v, input status_t st, input logic hex,
			input logic [7:0] stop, input logic by_end);
		literal_result_t r;
		r.value = v;
		r.status = st;
		r.was_hex = hex;
		r.stop_char = stop;
		r.stopped_by_end = by_end;
		expected_literals.push_back(r);
		lit_phase = LIT_IDLE;
		acc = '0;
	endtask

	task automatic parse_char(input logic [7:0] c, input logic eot);
		logic [7:0]  stop;
		logic [63:0] limit;
		logic [63:0] radix;
		logic [63:0] dv;
		logic        hex;
		bit          handled;
		int          d;
		stop = eot ? 8'h00 : c;
		handled = 1'b0;
		if (lit_phase == LIT_IDLE) begin
			handled = 1'b1;
			if (eot || c < CH_ZERO || c > CH_NINE) begin
				close_literal('0, ST_NO_DIGIT, 1'b0, stop, eot);
			end else if (c == CH_ZERO) begin
				lit_phase = LIT_ZEROS;
				acc = '0;
			end else begin
				lit_phase = LIT_DEC;
				acc = 64'(c - CH_ZERO);
			end
		end else if (lit_phase == LIT_ZEROS) begin
			handled = 1'b1;
			if (eot) begin
				close_literal('0, ST_OK, 1'b0, 8'h00, 1'b1);
			end else if (c == CH_LOWER_X || c == CH_UPPER_X) begin
				lit_phase = LIT_HEX;
				acc = '0;
			end else if (c != CH_ZERO) begin
				// Any other character is taken up by the decimal rules below.
				lit_phase = LIT_DEC;
				acc = '0;
				handled = 1'b0;
			end
		end
		if (!handled) begin
			hex = (lit_phase == LIT_HEX);
			radix = hex ? 64'd16 : 64'd10;
			limit = wide_mode ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
			d = digit_value(c, hex);
			if (eot) begin
				close_literal(acc & limit, ST_OK, hex, 8'h00, 1'b1);
			end else if (d < 0) begin
				close_literal(acc & limit, ST_OK, hex, c, 1'b0);
			end else begin
				dv = 64'(d);
				if (acc > limit / radix || acc * radix > limit - dv)
					close_literal('0, ST_OVERFLOW, hex, c, 1'b0);
				else
					acc = acc * radix + dv;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		literal_result_t want;
		if (!arst_n) begin
			wide_mode = 1'b1;
			lit_phase = LIT_IDLE;
			acc = '0;
			expected_literals.delete();
		end else begin
			if (cfg_we)
				wide_mode = cfg_wdata;
			if (out_valid && out_ready) begin
				if (expected_literals.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %h status %0d",
						value, status));
				end else begin
					want = expected_literals.pop_front();
					if (value !== want.value)
						report_mismatch($sformatf("value %h, expected %h", value, want.value));
					if (status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							status, want.status));
					if (was_hex !== want.was_hex)
						report_mismatch($sformatf("was_hex %b, expected %b",
							was_hex, want.was_hex));
					if (stop_char !== want.stop_char)
						report_mismatch($sformatf("stop_char %h, expected %h",
							stop_char, want.stop_char));
					if (stopped_by_end !== want.stopped_by_end)
						report_mismatch($sformatf("stopped_by_end %b, expected %b",
							stopped_by_end, want.stopped_by_end));
				end
			end
			if (in_valid && in_ready)
				parse_char(char_code, end_of_text);
		end
		pending_results = expected_literals.size();
	end

endmodule

[tb/unsigned_integer_literal_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unsigned integer literal parser testbench
// Feeds short directed literals, a back-pressure burst and random decimal and
// hex literals at both widths under several idle and stall patterns; the
// checker beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module unsigned_integer_literal_parser_tb;
	import ulp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_ITEMS  = 50;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        end_of_text;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] value;
	status_t     status;
	logic        was_hex;
	logic [7:0]  stop_char;
	logic        stopped_by_end;
	int          mismatches;
	int          pending_results;

	int          sender_idle_pct = 0;
	int          stall_pct = 0;
	int          sent_items = 0;
	int          cycles = 0;
	logic        width_now = 1'b1;
	logic        hold_go = 1'b0;
	logic        holding = 1'b0;

	unsigned_integer_literal_parser u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.end_of_text    (end_of_text),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.status         (status),
		.was_hex        (was_hex),
		.stop_char      (stop_char),
		.stopped_by_end (stopped_by_end)
	);

	literal_parse_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= !holding && ($urandom_range(99) >= stall_pct);
	end

	// The receiver holds off for a long stretch once, while items keep coming.
	initial begin
		wait (hold_go);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	task automatic send_item(input logic [7:0] c, input logic eot);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
	endtask

	task automatic send_end();
		send_item(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic send_chars(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		// A digit that causes no result may still be inside the parser.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(input logic w);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		width_now = w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_literal();
		int          kind;
		int          n;
		int          r;
		bit          hex_form;
		string       digits;
		logic [63:0] top;
		kind = $urandom_range(19);
		top = width_now ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
		hex_form = (kind >= 16) ? bit'($urandom_range(1)) : (kind >= 10);
		if (kind < 2) begin
			send_item(8'($urandom_range(255)), 1'b0);
		end else if (kind == 2) begin
			send_end();
		end else begin
			if (hex_form) begin
				repeat ($urandom_range(1, 2)) send_item(CH_ZERO, 1'b0);
				send_item($urandom_range(1) ? CH_LOWER_X : CH_UPPER_X, 1'b0);
			end else if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 3)) send_item(CH_ZERO, 1'b0);
			end
			if (kind >= 16) begin
				// Largest value of the width, one digit past it, or a bumped last digit.
				digits = hex_form ? $sformatf("%0h", top) : $sformatf("%0d", top);
				r = $urandom_range(2);
				if (r == 2 && !hex_form) begin
					send_chars(digits.substr(0, digits.len() - 2));
					send_item(8'(digits[digits.len() - 1] + $urandom_range(1, 4)), 1'b0);
				end else begin
					send_chars(digits);
					if (r != 0)
						send_item(8'(CH_ZERO + $urandom_range(9)), 1'b0);
				end
			end else begin
				n = ($urandom_range(4) == 0) ? $urandom_range(11, 22)
					: $urandom_range(hex_form ? 0 : 1, 10);
				repeat (n) begin
					r = $urandom_range(hex_form ? 15 : 9);
					if (r < 10)
						send_item(8'(CH_ZERO + r), 1'b0);
					else
						send_item(8'(($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + r - 10),
							1'b0);
				end
			end
			r = $urandom_range(9);
			if (r < 4)
				send_end();
			else if (r < 9)
				send_item(8'($urandom_range(255)), 1'b0);
		end
	endtask

	initial begin
		int phase_start;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		char_code <= 8'h00;
		end_of_text <= 1'b0;
		out_ready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_end();
		send_chars("x");
		send_item(8'hFF, 1'b0);
		send_chars("0");
		send_end();
		send_chars("0xg");
		send_chars("0XaF ");
		send_chars("007");
		send_end();
		send_chars("09a");
		send_chars("5:");

		// Every non-digit at the start ends a literal at once, so the parser fills up.
		hold_go = 1'b1;
		repeat (24) send_item(8'($urandom_range(47)), 1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			set_width(1'(ph % 2));
			case (ph % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 83; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 83; end
				default: begin sender_idle_pct = 29; stall_pct = 29; end
			endcase
			phase_start = sent_items;
			while (sent_items - phase_start < PHASE_ITEMS)
				send_random_literal();
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
